// ===== design/frame_pacing_timebase_core_assert.svh =====
// Assertion macros shared by the frame pacing timebase modules.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef FRAME_PACING_TIMEBASE_CORE_ASSERT_SVH
`define FRAME_PACING_TIMEBASE_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset
`define FPT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define FPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fpt_pkg.sv =====
`timescale 1ns / 1ps

package fpt_pkg;

    // Field widths
    localparam int NOW_W      = 32;
    localparam int RATE_W     = 7;
    localparam int FPS_W      = 8;
    localparam int SEC_W      = 6;
    localparam int EV_W       = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [RATE_W-1:0] RATE_RESET = 7'd10;
    localparam logic [SEC_W-1:0]  LAST_SEC   = 6'd59;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EV_W-1:0] EV_FRAME  = 3'd1;
    localparam logic [EV_W-1:0] EV_SECOND = 3'd2;
    localparam logic [EV_W-1:0] EV_MINUTE = 3'd3;
    localparam logic [EV_W-1:0] EV_HOUR   = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_load;
        logic div_step;
        logic load_sample;
        logic mul;
        logic update;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ===== design/fpt_ctrl.sv =====
`timescale 1ns / 1ps
`include "frame_pacing_timebase_core_assert.svh"

module fpt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  fpt_pkg::status_t status,
    output fpt_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Accept configuration first; items wait while a write is offered
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;

    // Sequence commands
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_load = 1'b1;
                    state_next   = S_DIV;
                end else if (s_tvalid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_MUL;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_IDLE;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `FPT_ASSERT_NEXT(a_item_to_mul, s_tvalid && s_tready, state_reg == S_MUL, "item not multiplied")
    `FPT_ASSERT_NEXT(a_mul_to_upd, state_reg == S_MUL, state_reg == S_UPD, "multiply did not advance")
    `FPT_ASSERT_NEXT(a_upd_holds, (state_reg == S_UPD) && !status.out_free, state_reg == S_UPD, "update dropped while output full")
    `FPT_ASSERT_NEXT(a_cfg_to_div, cfg_valid && cfg_ready, state_reg == S_DIV, "config write did not start divide")

endmodule

// ===== design/fpt_dp.sv =====
`timescale 1ns / 1ps
`include "frame_pacing_timebase_core_assert.svh"

module fpt_dp #(
    parameter int TICKS_PER_SECOND = 100
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fpt_pkg::cmd_t                     cmd,
    output fpt_pkg::status_t                  status,
    input  logic [fpt_pkg::NOW_W-1:0]         s_tdata,
    input  logic [fpt_pkg::RATE_W-1:0]        cfg_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [fpt_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    localparam int PW = $clog2(TICKS_PER_SECOND + 1);
    localparam int CW = $clog2(PW + 1);
    localparam int MW = PW + fpt_pkg::FPS_W + 1;
    localparam logic [PW-1:0] TPS_P        = PW'(TICKS_PER_SECOND);
    localparam logic [PW-1:0] PERIOD_RESET = PW'(TICKS_PER_SECOND / 10);
    localparam logic [fpt_pkg::NOW_W-1:0] TPS_N    = 32'(TICKS_PER_SECOND);
    localparam logic [fpt_pkg::NOW_W-1:0] TPS_M1_N = 32'(TICKS_PER_SECOND - 1);

    // Configuration and frame period
    logic [fpt_pkg::RATE_W-1:0] rate_reg;
    logic [PW-1:0]              period_reg;
    logic [fpt_pkg::RATE_W-1:0] div_rem_reg;
    logic [PW-1:0]              div_q_reg;
    logic [CW-1:0]              div_cnt_reg;

    // Pacing state
    logic                       started_reg,   started_next;
    logic [fpt_pkg::NOW_W-1:0]  base_reg,      base_next;
    logic [fpt_pkg::FPS_W-1:0]  frame_cnt_reg, frame_cnt_next;
    logic [fpt_pkg::FPS_W-1:0]  fps_reg,       fps_next;
    logic [fpt_pkg::SEC_W-1:0]  second_reg,    second_next;
    logic [fpt_pkg::SEC_W-1:0]  minute_reg,    minute_next;

    // Per-item working registers
    logic [fpt_pkg::NOW_W-1:0]  now_reg;
    logic [fpt_pkg::NOW_W-1:0]  elapsed_reg;
    logic                       back_reg;
    logic [MW-1:0]              prod_reg;

    // Output register
    logic                       out_valid_reg;
    logic [fpt_pkg::EV_W-1:0]   out_event_reg, out_event_next;
    logic                       out_err_reg;
    logic [fpt_pkg::FPS_W-1:0]  out_fps_reg;
    logic [fpt_pkg::SEC_W-1:0]  out_sec_reg;
    logic [fpt_pkg::SEC_W-1:0]  out_min_reg;

    // Restoring divider step: TICKS_PER_SECOND / rate, one quotient bit a cycle
    logic [fpt_pkg::RATE_W-1:0] div_d;
    logic [fpt_pkg::RATE_W:0]   div_trial;
    logic                       div_ge;
    logic [fpt_pkg::RATE_W-1:0] div_rem_step;
    logic [PW-1:0]              div_q_step;

    always_comb begin
        div_d        = (rate_reg == '0) ? 7'd1 : rate_reg;
        div_trial    = {div_rem_reg, div_q_reg[PW-1]};
        div_ge       = (div_trial >= {1'b0, div_d});
        div_rem_step = div_ge ? 7'(div_trial - {1'b0, div_d}) : div_trial[fpt_pkg::RATE_W-1:0];
        div_q_step   = {div_q_reg[PW-2:0], div_ge};
    end

    assign status.div_last = (div_cnt_reg == CW'(PW - 1));
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= fpt_pkg::RATE_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cmd.cfg_load) begin
            rate_reg <= cfg_data;
        end else if (cmd.div_step && status.div_last) begin
            period_reg <= (div_q_step == '0) ? PW'(1) : div_q_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cfg_load) begin
            div_rem_reg <= '0;
            div_q_reg   <= TPS_P;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_rem_reg <= div_rem_step;
            div_q_reg   <= div_q_step;
            div_cnt_reg <= div_cnt_reg + CW'(1);
        end
    end

    // Capture the sample, then form elapsed ticks and the next frame deadline
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            now_reg <= s_tdata;
        end
        if (cmd.mul) begin
            back_reg    <= (base_reg > now_reg);
            elapsed_reg <= (base_reg > now_reg) ? '0 : now_reg - base_reg;
            prod_reg    <= MW'({1'b0, frame_cnt_reg} + 9'd1) * MW'(period_reg);
        end
    end

    // Apply one sample to the pacing state; a configuration write clears it
    logic                      clk_err;
    logic                      frame_due;
    logic [fpt_pkg::NOW_W-1:0] base_eff;
    logic [fpt_pkg::FPS_W-1:0] frame_inc;

    always_comb begin
        clk_err        = (now_reg == '1);
        frame_due      = (32'(prod_reg) <= elapsed_reg);
        base_eff       = back_reg ? now_reg : base_reg;
        frame_inc      = (frame_cnt_reg == '1) ? frame_cnt_reg : frame_cnt_reg + 8'd1;
        started_next   = started_reg;
        base_next      = base_reg;
        frame_cnt_next = frame_cnt_reg;
        fps_next       = fps_reg;
        second_next    = second_reg;
        minute_next    = minute_reg;
        out_event_next = fpt_pkg::EV_NONE;
        if (cmd.cfg_load) begin
            started_next   = 1'b0;
            base_next      = '0;
            frame_cnt_next = '0;
            fps_next       = '0;
            second_next    = '0;
            minute_next    = '0;
        end else if (cmd.update && !clk_err) begin
            if (!started_reg) begin
                started_next   = 1'b1;
                frame_cnt_next = '0;
                base_next      = now_reg;
            end else begin
                base_next = base_eff;
                if (frame_due) begin
                    frame_cnt_next = frame_inc;
                    out_event_next = fpt_pkg::EV_FRAME;
                    if (elapsed_reg > TPS_M1_N) begin
                        fps_next       = frame_inc;
                        frame_cnt_next = '0;
                        base_next      = base_eff + TPS_N;
                        out_event_next = fpt_pkg::EV_SECOND;
                        second_next    = second_reg + 6'd1;
                        if (second_reg == fpt_pkg::LAST_SEC) begin
                            second_next    = '0;
                            minute_next    = minute_reg + 6'd1;
                            out_event_next = fpt_pkg::EV_MINUTE;
                            if (minute_reg == fpt_pkg::LAST_SEC) begin
                                minute_next    = '0;
                                out_event_next = fpt_pkg::EV_HOUR;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            base_reg      <= '0;
            frame_cnt_reg <= '0;
            fps_reg       <= '0;
            second_reg    <= '0;
            minute_reg    <= '0;
        end else begin
            started_reg   <= started_next;
            base_reg      <= base_next;
            frame_cnt_reg <= frame_cnt_next;
            fps_reg       <= fps_next;
            second_reg    <= second_next;
            minute_reg    <= minute_next;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            out_event_reg <= out_event_next;
            out_err_reg   <= clk_err;
            out_fps_reg   <= fps_next;
            out_sec_reg   <= second_next;
            out_min_reg   <= minute_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_err_reg;
    assign m_tdata  = {1'b0, out_min_reg, out_sec_reg, out_fps_reg, out_event_reg};

    `FPT_ASSERT_ALWAYS(a_period_nonzero, period_reg != '0, "frame period is zero")
    `FPT_ASSERT_ALWAYS(a_time_range,
        (second_reg <= fpt_pkg::LAST_SEC) && (minute_reg <= fpt_pkg::LAST_SEC),
        "seconds or minutes out of range")
    `FPT_ASSERT_NEXT(a_err_keeps_state, cmd.update && clk_err,
        $stable(base_reg) && $stable(frame_cnt_reg) && $stable(started_reg),
        "clock error changed state")

endmodule

// ===== design/frame_pacing_timebase_core.sv =====
// Frame pacing timebase: one result item per accepted sample item.
// Each sample is multiplied, then applied in the update step that registers the result.
// Samples are taken only when idle; the update waits while the output register is full.
// A frames_per_second write clears the pacing state and runs a bit-serial divider before the
// next item is taken.
// Reset (aresetn low, synchronous) clears the pacing state and sets the rate to 10 frames/s.
`timescale 1ns / 1ps

module frame_pacing_timebase_core #(
    parameter int TICKS_PER_SECOND = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    // now_ticks[31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // frames_per_second[6:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    // event_code[2:0], last_fps[10:3], second_count[16:11], minute_count[22:17], zero[23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // clock_error[0]
    output logic        m_tuser
);

    fpt_pkg::cmd_t    cmd;
    fpt_pkg::status_t status;

    fpt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fpt_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
